// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers with asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_AT(label, clk, rst_n, !(cond), msg)

`endif

// ===== hdl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, phase and command codes of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int HOLD_CW_DEFAULT = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_RESTART = 3'd2;
  localparam logic [2:0] CMD_STOP    = 3'd3;
  localparam logic [2:0] CMD_WRITE   = 3'd4;
  localparam logic [2:0] CMD_READ    = 3'd5;
  localparam logic [2:0] CMD_ADDR    = 3'd6;

  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_ST_A    = 5'd1;
  localparam logic [4:0] PH_RS_A    = 5'd2;
  localparam logic [4:0] PH_RS_B    = 5'd3;
  localparam logic [4:0] PH_SP_A    = 5'd4;
  localparam logic [4:0] PH_SP_B    = 5'd5;
  localparam logic [4:0] PH_GAP     = 5'd6;
  localparam logic [4:0] PH_TX_LOW  = 5'd7;
  localparam logic [4:0] PH_TX_HIGH = 5'd8;
  localparam logic [4:0] PH_ACK_A   = 5'd9;
  localparam logic [4:0] PH_ACK_B   = 5'd10;
  localparam logic [4:0] PH_ACK_C   = 5'd11;
  localparam logic [4:0] PH_RX_PRE  = 5'd12;
  localparam logic [4:0] PH_RX_HIGH = 5'd13;
  localparam logic [4:0] PH_RX_LOW  = 5'd14;
  localparam logic [4:0] PH_NA_A    = 5'd15;
  localparam logic [4:0] PH_CA_A    = 5'd16;
  localparam logic [4:0] PH_AK_END  = 5'd17;

  localparam logic [7:0] TEN_BIT_PREFIX = 8'hf0;
  localparam logic [7:0] TEN_BIT_HI_MSK = 8'h06;
  localparam logic [7:0] READ_BIT       = 8'h01;

  typedef struct packed {
    logic [2:0] mode;
    logic       sda_in;
    logic [7:0] write_data;
    logic [9:0] device_address;
    logic       ten_bit;
    logic       read_not_write;
    logic [7:0] retry_limit;
    logic       tolerate_nack;
    logic       last_read;
    logic       skip_ack;
  } item_t;

  typedef struct packed {
    item_t item;
    logic  is_cmd;
    logic  is_tick;
  } q_item_t;

  typedef struct packed {
    logic q_valid;
    logic take;
    logic iter;
  } eng_stat_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic       nack_seen;
    logic [7:0] read_data;
    logic       error;
  } result_t;

endpackage

// ===== hdl/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// i2cm_front
// Request queue: accepts stream requests, decodes the mode, buffers them.
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  i2cm_pkg::item_t   in_item_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output i2cm_pkg::q_item_t q_item_o
);

  i2cm_pkg::q_item_t mem_q [i2cm_pkg::QUEUE_DEPTH];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;
  i2cm_pkg::q_item_t entry;
  logic              push;

  always_comb begin
    entry.item    = in_item_i;
    entry.is_tick = (in_item_i.mode == i2cm_pkg::CMD_TICK);
    entry.is_cmd  = (in_item_i.mode >= i2cm_pkg::CMD_START) &&
                    (in_item_i.mode <= i2cm_pkg::CMD_ADDR);
  end

  assign in_ready_o = (count_q != 2'(i2cm_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

// ===== hdl/i2cm_engine.sv =====
// ----------------------------------------------------------------------------
// i2cm_engine
// Phase machine: runs commands and ticks, drives the lines, holds the result.
// ----------------------------------------------------------------------------
module i2cm_engine #(
  parameter int HOLD_COUNTER_WIDTH = i2cm_pkg::HOLD_CW_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          tpm_i,
  input  logic                q_valid_i,
  input  i2cm_pkg::q_item_t   q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output i2cm_pkg::result_t   out_o,
  output i2cm_pkg::eng_stat_t stat_o
);

  localparam int HW = HOLD_COUNTER_WIDTH;
  localparam logic [31:0] HMAX = (HW >= 32) ? 32'hffffffff : ((32'd1 << HW) - 32'd1);

  typedef struct packed {
    logic [4:0]    phase;
    logic [3:0]    bit_idx;
    logic [7:0]    shift;
    logic [HW-1:0] hold;
    logic [7:0]    attempt;
    logic [1:0]    astep;
    logic [7:0]    first;
    logic          scl;
    logic          sda;
    logic [2:0]    cmd;
    logic [7:0]    second;
    logic [7:0]    retry;
    logic          ten;
    logic          rnw;
    logic          ign;
    logic          last;
    logic          skip;
    logic          nack;
    logic          err;
    logic          done;
    logic [7:0]    rdata;
  } eng_t;

  function automatic eng_t reset_state();
    eng_t r;
    r     = '0;
    r.scl = 1'b1;
    r.sda = 1'b1;
    return r;
  endfunction

  function automatic eng_t wait_us(eng_t s, logic [2:0] n, logic [4:0] nxt,
                                   logic [7:0] tpm);
    logic [31:0] t;
    eng_t        r;
    r = s;
    t = 32'(n) * 32'(tpm);
    r.hold  = HW'((t > HMAX) ? HMAX : t);
    r.phase = nxt;
    return r;
  endfunction

  function automatic eng_t finish(eng_t s);
    eng_t r;
    r = s;
    r.phase = i2cm_pkg::PH_IDLE;
    r.hold  = '0;
    r.done  = 1'b1;
    return r;
  endfunction

  function automatic eng_t tx_begin(eng_t s, logic [7:0] tpm);
    eng_t r;
    r = s;
    r.bit_idx = 4'd7;
    r.scl     = 1'b0;
    r.sda     = s.shift[7];
    return wait_us(r, 3'd5, i2cm_pkg::PH_TX_LOW, tpm);
  endfunction

  function automatic eng_t start_seq(eng_t s, logic [7:0] tpm);
    eng_t r;
    r = s;
    r.sda = 1'b0;
    return wait_us(r, 3'd3, i2cm_pkg::PH_ST_A, tpm);
  endfunction

  function automatic eng_t restart_seq(eng_t s, logic [7:0] tpm);
    eng_t r;
    r = s;
    r.sda = 1'b1;
    r.scl = 1'b1;
    return wait_us(r, 3'd3, i2cm_pkg::PH_RS_A, tpm);
  endfunction

  function automatic eng_t stop_seq(eng_t s, logic [7:0] tpm);
    eng_t r;
    r = s;
    r.sda = 1'b0;
    r.scl = 1'b1;
    return wait_us(r, 3'd3, i2cm_pkg::PH_SP_A, tpm);
  endfunction

  function automatic eng_t after_byte(eng_t s, logic nack, logic [7:0] tpm);
    eng_t r;
    r = s;
    r.nack = nack;
    if (s.cmd != i2cm_pkg::CMD_ADDR) begin
      r.err = nack && !s.ign;
      r = finish(r);
    end else if (nack && (s.attempt != s.retry)) begin
      r.attempt = s.attempt + 8'd1;
      r = stop_seq(r, tpm);
    end else if (nack && !s.ign) begin
      r.err = 1'b1;
      r = finish(r);
    end else if (!s.ten) begin
      r = finish(r);
    end else if (s.astep == 2'd0) begin
      r.astep   = 2'd1;
      r.shift   = s.second;
      r.attempt = 8'd0;
      r = tx_begin(r, tpm);
    end else if ((s.astep == 2'd1) && s.rnw) begin
      r.astep   = 2'd2;
      r.shift   = s.first | i2cm_pkg::READ_BIT;
      r.attempt = 8'd0;
      r = restart_seq(r, tpm);
    end else begin
      r = finish(r);
    end
    return r;
  endfunction

  function automatic eng_t advance(eng_t s, logic sda, logic [7:0] tpm);
    eng_t r;
    r = s;
    case (s.phase)
      i2cm_pkg::PH_ST_A, i2cm_pkg::PH_RS_B: begin
        r.scl = 1'b0;
        r = (s.cmd == i2cm_pkg::CMD_ADDR) ? tx_begin(r, tpm) : finish(r);
      end
      i2cm_pkg::PH_RS_A: begin
        r.sda = 1'b0;
        r = wait_us(r, 3'd3, i2cm_pkg::PH_RS_B, tpm);
      end
      i2cm_pkg::PH_SP_A: begin
        r.sda = 1'b1;
        r = wait_us(r, 3'd5, i2cm_pkg::PH_SP_B, tpm);
      end
      i2cm_pkg::PH_SP_B: begin
        r = (s.cmd == i2cm_pkg::CMD_ADDR) ? wait_us(r, 3'd5, i2cm_pkg::PH_GAP, tpm)
                                          : finish(r);
      end
      i2cm_pkg::PH_GAP: r = start_seq(r, tpm);
      i2cm_pkg::PH_TX_LOW: begin
        r.scl = 1'b1;
        r = wait_us(r, 3'd3, i2cm_pkg::PH_TX_HIGH, tpm);
      end
      i2cm_pkg::PH_TX_HIGH: begin
        r.scl = 1'b0;
        if (s.bit_idx != 4'd0) begin
          r.bit_idx = s.bit_idx - 4'd1;
          r.sda     = s.shift[r.bit_idx[2:0]];
          r = wait_us(r, 3'd5, i2cm_pkg::PH_TX_LOW, tpm);
        end else begin
          r = wait_us(r, 3'd3, i2cm_pkg::PH_ACK_A, tpm);
        end
      end
      i2cm_pkg::PH_ACK_A: begin
        r.sda = 1'b1;
        r = wait_us(r, 3'd3, i2cm_pkg::PH_ACK_B, tpm);
      end
      i2cm_pkg::PH_ACK_B: begin
        r.scl = 1'b1;
        r = wait_us(r, 3'd3, i2cm_pkg::PH_ACK_C, tpm);
      end
      i2cm_pkg::PH_ACK_C: begin
        r.scl = 1'b0;
        r = after_byte(r, sda, tpm);
      end
      i2cm_pkg::PH_RX_PRE: begin
        r.scl = 1'b1;
        r = wait_us(r, 3'd3, i2cm_pkg::PH_RX_HIGH, tpm);
      end
      i2cm_pkg::PH_RX_HIGH: begin
        r.shift = {s.shift[6:0], sda};
        r.scl   = 1'b0;
        r = wait_us(r, 3'd5, i2cm_pkg::PH_RX_LOW, tpm);
      end
      i2cm_pkg::PH_RX_LOW: begin
        r.bit_idx = s.bit_idx + 4'd1;
        if (r.bit_idx < 4'd8) begin
          r.scl = 1'b1;
          r = wait_us(r, 3'd3, i2cm_pkg::PH_RX_HIGH, tpm);
        end else begin
          r.rdata = s.shift;
          if (s.last) begin
            r.sda = 1'b1;
            r = wait_us(r, 3'd2, i2cm_pkg::PH_NA_A, tpm);
          end else if (!s.skip) begin
            r.sda = 1'b0;
            r = wait_us(r, 3'd2, i2cm_pkg::PH_CA_A, tpm);
          end else begin
            r = finish(r);
          end
        end
      end
      i2cm_pkg::PH_NA_A: begin
        r.scl = 1'b1;
        r = wait_us(r, 3'd2, i2cm_pkg::PH_AK_END, tpm);
      end
      i2cm_pkg::PH_CA_A: begin
        r.scl = 1'b1;
        r = wait_us(r, 3'd3, i2cm_pkg::PH_AK_END, tpm);
      end
      i2cm_pkg::PH_AK_END: begin
        r.scl = 1'b0;
        r = finish(r);
      end
      default: begin
        r.phase = i2cm_pkg::PH_IDLE;
        r.hold  = '0;
      end
    endcase
    return r;
  endfunction

  eng_t              st_q, st_d, s;
  logic              iter_q, iter_d;
  logic              sda_q, sda_d, sda_b;
  logic              out_valid_q, out_valid_d;
  i2cm_pkg::result_t out_q, out_d;
  logic              en, take, step, run, more;
  i2cm_pkg::item_t   it;

  assign it = q_item_i.item;

  always_comb begin
    en    = !out_valid_q || out_ready_i;
    take  = en && !iter_q && q_valid_i;
    step  = take || (iter_q && en);
    s     = st_q;
    sda_b = sda_q;
    run   = iter_q;
    if (take) begin
      s.done = 1'b0;
      sda_b  = it.sda_in;
      if (st_q.phase == i2cm_pkg::PH_IDLE) begin
        if (q_item_i.is_cmd) begin
          s.cmd   = it.mode;
          s.ten   = it.ten_bit;
          s.rnw   = it.read_not_write;
          s.retry = it.retry_limit;
          s.ign   = it.tolerate_nack;
          s.last  = it.last_read;
          s.skip  = it.skip_ack;
          s.err   = 1'b0;
          run     = 1'b1;
          case (it.mode)
            i2cm_pkg::CMD_START:   s = start_seq(s, tpm_i);
            i2cm_pkg::CMD_RESTART: s = restart_seq(s, tpm_i);
            i2cm_pkg::CMD_STOP:    s = stop_seq(s, tpm_i);
            i2cm_pkg::CMD_WRITE: begin
              s.nack  = 1'b0;
              s.shift = it.write_data;
              s = tx_begin(s, tpm_i);
            end
            i2cm_pkg::CMD_READ: begin
              s.scl     = 1'b0;
              s.sda     = 1'b1;
              s.shift   = 8'd0;
              s.bit_idx = 4'd0;
              s = wait_us(s, 3'd3, i2cm_pkg::PH_RX_PRE, tpm_i);
            end
            default: begin
              s.nack = 1'b0;
              if (it.ten_bit) begin
                s.first  = i2cm_pkg::TEN_BIT_PREFIX |
                           (8'(it.device_address >> 7) & i2cm_pkg::TEN_BIT_HI_MSK);
                s.second = it.device_address[7:0];
              end else begin
                s.first = {it.device_address[6:0], it.read_not_write};
              end
              s.shift   = s.first;
              s.attempt = 8'd0;
              s.astep   = 2'd0;
              s = tx_begin(s, tpm_i);
            end
          endcase
        end
      end else if (q_item_i.is_tick) begin
        if (s.hold != '0) s.hold = s.hold - HW'(1);
        run = 1'b1;
      end
    end
    if (en && run && (s.phase != i2cm_pkg::PH_IDLE) && (s.hold == '0)) begin
      s = advance(s, sda_b, tpm_i);
    end
    more = run && (s.phase != i2cm_pkg::PH_IDLE) && (s.hold == '0);

    st_d   = step ? s : st_q;
    iter_d = step ? more : iter_q;
    sda_d  = sda_b;

    out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (step && !more) begin
      out_valid_d       = 1'b1;
      out_d.scl_level   = s.scl;
      out_d.sda_release = s.sda;
      out_d.busy_res    = (s.phase != i2cm_pkg::PH_IDLE);
      out_d.done_res    = s.done;
      out_d.nack_seen   = s.nack;
      out_d.read_data   = s.rdata;
      out_d.error       = s.err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= reset_state();
      iter_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sda_q <= sda_d;
    out_q <= out_d;
  end

  assign q_pop_o     = take;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign stat_o      = '{q_valid: q_valid_i, take: take, iter: iter_q};

endmodule

// ===== hdl/i2c_master_byte_engine.sv =====
// Request path: the queue entry register, then the phase machine, then the result register.
// Throughput: one request per cycle while ticks_per_microsecond is nonzero and results are not back-pressured.
// With a zero timing register the phase machine walks one phase per cycle, while
// results are not back-pressured, until the command ends; no new request is taken meanwhile.
// Reset: asynchronous, active low; lines released, engine idle, queue empty.
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master byte engine: request queue in front of the phase machine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_byte_engine #(
  parameter int HOLD_COUNTER_WIDTH = i2cm_pkg::HOLD_CW_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sda_in, write_data, device_address, ten_bit, read_not_write,
  // retry_limit, tolerate_nack, last_read, skip_ack
  input  logic [31:0] s_axis_tdata,
  // mode
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_level, sda_release, busy_res, done_res, nack_seen, read_data, error
  output logic [15:0] m_axis_tdata
);

  logic [7:0]          tpm_q;
  i2cm_pkg::item_t     in_item;
  i2cm_pkg::q_item_t   q_item;
  logic                q_valid, q_pop;
  i2cm_pkg::result_t   res;
  i2cm_pkg::eng_stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q <= 8'd1;
    end else if (cfg_we_i) begin
      tpm_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    in_item.mode           = s_axis_tuser;
    in_item.sda_in         = s_axis_tdata[0];
    in_item.write_data     = s_axis_tdata[8:1];
    in_item.device_address = s_axis_tdata[18:9];
    in_item.ten_bit        = s_axis_tdata[19];
    in_item.read_not_write = s_axis_tdata[20];
    in_item.retry_limit    = s_axis_tdata[28:21];
    in_item.tolerate_nack  = s_axis_tdata[29];
    in_item.last_read      = s_axis_tdata[30];
    in_item.skip_ack       = s_axis_tdata[31];
  end

  i2cm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  i2cm_engine #(
    .HOLD_COUNTER_WIDTH (HOLD_COUNTER_WIDTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tpm_i       (tpm_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res),
    .stat_o      (stat)
  );

  assign m_axis_tdata = {2'b00, res.error, res.read_data, res.nack_seen, res.done_res,
                         res.busy_res, res.sda_release, res.scl_level};

  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, stat.take && !stat.q_valid, "pop from empty queue")
  `ASSERT_NEVER(a_pop_iter, clk_i, rst_ni, stat.take && stat.iter, "pop while iterating")
  `ASSERT_NEVER(a_done_busy, clk_i, rst_ni, m_axis_tvalid && res.done_res && res.busy_res, "done while busy")

endmodule

// ===== tb/i2c_master_byte_engine_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_checker
// Watches the request and result streams of the I2C master byte engine,
// predicts the line levels and status of every request and compares each
// result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic [2:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output logic        engine_busy_o
);

  localparam int HOLD_W = i2cm_pkg::HOLD_CW_DEFAULT;
  localparam longint unsigned HOLD_MAX = (64'd1 << HOLD_W) - 1;

  logic [7:0]  tpm;
  logic [4:0]  phase;
  logic [3:0]  bit_idx;
  logic [7:0]  shreg;
  longint unsigned hold;
  logic [7:0]  attempts;
  logic [1:0]  addr_stage;
  logic [7:0]  first_byte;
  logic [7:0]  second_byte;
  logic        scl, sda;
  logic [2:0]  cmd;
  logic [7:0]  retry_lim;
  logic        ten, rnw, ign, last_rd, skip;
  logic        nack, err, done;
  logic [7:0]  rdata;
  i2cm_pkg::result_t line_status_q[$];
  int          fails;

  function automatic void hold_for(input int unsigned n, input logic [4:0] nxt);
    longint unsigned t;
    t = longint'(n) * tpm;
    if (t > HOLD_MAX) t = HOLD_MAX;
    hold = t;
    phase = nxt;
  endfunction

  function automatic void end_cmd();
    phase = i2cm_pkg::PH_IDLE;
    hold = 0;
    done = 1'b1;
  endfunction

  function automatic void load_tx();
    bit_idx = 4'd7;
    scl = 1'b0;
    sda = shreg[7];
    hold_for(5, i2cm_pkg::PH_TX_LOW);
  endfunction

  function automatic void begin_start();
    sda = 1'b0;
    hold_for(3, i2cm_pkg::PH_ST_A);
  endfunction

  function automatic void begin_restart();
    sda = 1'b1;
    scl = 1'b1;
    hold_for(3, i2cm_pkg::PH_RS_A);
  endfunction

  function automatic void begin_stop();
    sda = 1'b0;
    scl = 1'b1;
    hold_for(3, i2cm_pkg::PH_SP_A);
  endfunction

  function automatic void byte_acked(input logic nk);
    nack = nk;
    if (cmd != i2cm_pkg::CMD_ADDR) begin
      err = nk && !ign;
      end_cmd();
    end else if (nk && attempts != retry_lim) begin
      attempts = attempts + 8'd1;
      begin_stop();
    end else if (nk && !ign) begin
      err = 1'b1;
      end_cmd();
    end else if (!ten) begin
      end_cmd();
    end else if (addr_stage == 2'd0) begin
      addr_stage = 2'd1;
      shreg = second_byte;
      attempts = 8'd0;
      load_tx();
    end else if (addr_stage == 2'd1 && rnw) begin
      addr_stage = 2'd2;
      shreg = first_byte | i2cm_pkg::READ_BIT;
      attempts = 8'd0;
      begin_restart();
    end else begin
      end_cmd();
    end
  endfunction

  function automatic void phase_step(input logic sda_s);
    case (phase)
      i2cm_pkg::PH_ST_A, i2cm_pkg::PH_RS_B: begin
        scl = 1'b0;
        if (cmd == i2cm_pkg::CMD_ADDR) load_tx();
        else end_cmd();
      end
      i2cm_pkg::PH_RS_A: begin
        sda = 1'b0;
        hold_for(3, i2cm_pkg::PH_RS_B);
      end
      i2cm_pkg::PH_SP_A: begin
        sda = 1'b1;
        hold_for(5, i2cm_pkg::PH_SP_B);
      end
      i2cm_pkg::PH_SP_B: begin
        if (cmd == i2cm_pkg::CMD_ADDR) hold_for(5, i2cm_pkg::PH_GAP);
        else end_cmd();
      end
      i2cm_pkg::PH_GAP: begin_start();
      i2cm_pkg::PH_TX_LOW: begin
        scl = 1'b1;
        hold_for(3, i2cm_pkg::PH_TX_HIGH);
      end
      i2cm_pkg::PH_TX_HIGH: begin
        scl = 1'b0;
        if (bit_idx > 0) begin
          bit_idx = bit_idx - 4'd1;
          sda = shreg[bit_idx[2:0]];
          hold_for(5, i2cm_pkg::PH_TX_LOW);
        end else begin
          hold_for(3, i2cm_pkg::PH_ACK_A);
        end
      end
      i2cm_pkg::PH_ACK_A: begin
        sda = 1'b1;
        hold_for(3, i2cm_pkg::PH_ACK_B);
      end
      i2cm_pkg::PH_ACK_B: begin
        scl = 1'b1;
        hold_for(3, i2cm_pkg::PH_ACK_C);
      end
      i2cm_pkg::PH_ACK_C: begin
        scl = 1'b0;
        byte_acked(sda_s);
      end
      i2cm_pkg::PH_RX_PRE: begin
        scl = 1'b1;
        hold_for(3, i2cm_pkg::PH_RX_HIGH);
      end
      i2cm_pkg::PH_RX_HIGH: begin
        shreg = {shreg[6:0], sda_s};
        scl = 1'b0;
        hold_for(5, i2cm_pkg::PH_RX_LOW);
      end
      i2cm_pkg::PH_RX_LOW: begin
        bit_idx = bit_idx + 4'd1;
        if (bit_idx < 4'd8) begin
          scl = 1'b1;
          hold_for(3, i2cm_pkg::PH_RX_HIGH);
        end else begin
          rdata = shreg;
          if (last_rd) begin
            sda = 1'b1;
            hold_for(2, i2cm_pkg::PH_NA_A);
          end else if (!skip) begin
            sda = 1'b0;
            hold_for(2, i2cm_pkg::PH_CA_A);
          end else begin
            end_cmd();
          end
        end
      end
      i2cm_pkg::PH_NA_A: begin
        scl = 1'b1;
        hold_for(2, i2cm_pkg::PH_AK_END);
      end
      i2cm_pkg::PH_CA_A: begin
        scl = 1'b1;
        hold_for(3, i2cm_pkg::PH_AK_END);
      end
      i2cm_pkg::PH_AK_END: begin
        scl = 1'b0;
        end_cmd();
      end
      default: begin
        phase = i2cm_pkg::PH_IDLE;
        hold = 0;
      end
    endcase
  endfunction

  function automatic i2cm_pkg::result_t engine_step(input i2cm_pkg::item_t it);
    logic              go;
    i2cm_pkg::result_t r;
    go = 1'b0;
    done = 1'b0;
    if (phase == i2cm_pkg::PH_IDLE) begin
      if (it.mode >= i2cm_pkg::CMD_START && it.mode <= i2cm_pkg::CMD_ADDR) begin
        cmd = it.mode;
        ten = it.ten_bit;
        rnw = it.read_not_write;
        retry_lim = it.retry_limit;
        ign = it.tolerate_nack;
        last_rd = it.last_read;
        skip = it.skip_ack;
        err = 1'b0;
        go = 1'b1;
        case (it.mode)
          i2cm_pkg::CMD_START: begin_start();
          i2cm_pkg::CMD_RESTART: begin_restart();
          i2cm_pkg::CMD_STOP: begin_stop();
          i2cm_pkg::CMD_WRITE: begin
            nack = 1'b0;
            shreg = it.write_data;
            load_tx();
          end
          i2cm_pkg::CMD_READ: begin
            scl = 1'b0;
            sda = 1'b1;
            shreg = 8'd0;
            bit_idx = 4'd0;
            hold_for(3, i2cm_pkg::PH_RX_PRE);
          end
          default: begin
            nack = 1'b0;
            if (ten) begin
              first_byte = i2cm_pkg::TEN_BIT_PREFIX |
                           ({5'd0, it.device_address[9:8], 1'b0} &
                            i2cm_pkg::TEN_BIT_HI_MSK);
              second_byte = it.device_address[7:0];
            end else begin
              first_byte = {it.device_address[6:0], rnw};
            end
            shreg = first_byte;
            attempts = 8'd0;
            addr_stage = 2'd0;
            load_tx();
          end
        endcase
      end
    end else if (it.mode == i2cm_pkg::CMD_TICK) begin
      if (hold > 0) hold--;
      go = 1'b1;
    end
    if (go) begin
      while (phase != i2cm_pkg::PH_IDLE && hold == 0) phase_step(it.sda_in);
    end
    r.scl_level = scl;
    r.sda_release = sda;
    r.busy_res = (phase != i2cm_pkg::PH_IDLE);
    r.done_res = done;
    r.nack_seen = nack;
    r.read_data = rdata;
    r.error = err;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] e,
                                      input logic [7:0] a);
    if (e !== a) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, e, a);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    i2cm_pkg::item_t   it;
    i2cm_pkg::result_t got, want;
    if (!rst_ni) begin
      tpm = 8'd1;
      phase = i2cm_pkg::PH_IDLE;
      bit_idx = 4'd0;
      shreg = 8'd0;
      hold = 0;
      attempts = 8'd0;
      addr_stage = 2'd0;
      first_byte = 8'd0;
      second_byte = 8'd0;
      scl = 1'b1;
      sda = 1'b1;
      cmd = i2cm_pkg::CMD_TICK;
      retry_lim = 8'd0;
      {ten, rnw, ign, last_rd, skip} = '0;
      {nack, err, done} = '0;
      rdata = 8'd0;
      fails = 0;
      line_status_q.delete();
    end else begin
      if (cfg_we_i) tpm = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) begin
        it.mode = s_tuser_i;
        it.sda_in = s_tdata_i[0];
        it.write_data = s_tdata_i[8:1];
        it.device_address = s_tdata_i[18:9];
        it.ten_bit = s_tdata_i[19];
        it.read_not_write = s_tdata_i[20];
        it.retry_limit = s_tdata_i[28:21];
        it.tolerate_nack = s_tdata_i[29];
        it.last_read = s_tdata_i[30];
        it.skip_ack = s_tdata_i[31];
        line_status_q.push_back(engine_step(it));
      end
      if (m_tvalid_i && m_tready_i) begin
        got.scl_level = m_tdata_i[0];
        got.sda_release = m_tdata_i[1];
        got.busy_res = m_tdata_i[2];
        got.done_res = m_tdata_i[3];
        got.nack_seen = m_tdata_i[4];
        got.read_data = m_tdata_i[12:5];
        got.error = m_tdata_i[13];
        if (line_status_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, m_tdata_i);
          fails++;
        end else begin
          want = line_status_q.pop_front();
          check_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
          check_field("sda_release", 8'(want.sda_release), 8'(got.sda_release));
          check_field("busy", 8'(want.busy_res), 8'(got.busy_res));
          check_field("done", 8'(want.done_res), 8'(got.done_res));
          check_field("nack_seen", 8'(want.nack_seen), 8'(got.nack_seen));
          check_field("read_data", want.read_data, got.read_data);
          check_field("error", 8'(want.error), 8'(got.error));
        end
      end
    end
    fail_count_o <= fails;
    pending_o <= line_status_q.size();
    engine_busy_o <= (phase != i2cm_pkg::PH_IDLE);
  end

endmodule

// ===== tb/i2c_master_byte_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_tb
// Drives tick and command requests into the I2C master byte engine under
// several timing register settings with random stalls on both streams;
// a checker beside the engine predicts and compares every result.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_tb;

  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  logic        engine_busy;
  logic        tx_burst;
  int          stall_cnt = 0;

  i2c_master_byte_engine uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  i2c_master_byte_engine_checker checker_i (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata),
    .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata),
    .fail_count_o(fail_count),
    .pending_o(pending),
    .engine_busy_o(engine_busy)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic i2cm_pkg::item_t rand_request(input logic [2:0] mode);
    i2cm_pkg::item_t it;
    it.mode = mode;
    it.sda_in = 1'($urandom_range(0, 1));
    it.write_data = 8'($urandom_range(0, 255));
    it.device_address = 10'($urandom_range(0, 1023));
    it.ten_bit = 1'($urandom_range(0, 1));
    it.read_not_write = 1'($urandom_range(0, 1));
    it.retry_limit = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 3));
    it.tolerate_nack = 1'($urandom_range(0, 1));
    it.last_read = 1'($urandom_range(0, 1));
    it.skip_ack = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic push(input i2cm_pkg::item_t it);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tuser <= it.mode;
    s_axis_tdata <= {it.skip_ack, it.last_read, it.tolerate_nack, it.retry_limit,
                     it.read_not_write, it.ten_bit, it.device_address,
                     it.write_data, it.sda_in};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic tick();
    push(rand_request(i2cm_pkg::CMD_TICK));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic finish_cmds();
    drain();
    while (engine_busy) begin
      tick();
      drain();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_rate(input logic [7:0] v);
    finish_cmds();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_traffic(input int n);
    int    k;
    int    r;
    logic [2:0] m;
    for (k = 0; k < n; k++) begin
      if (k % 64 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (engine_busy) begin
        if (r < 94) m = i2cm_pkg::CMD_TICK;
        else if (r < 98) m = 3'($urandom_range(i2cm_pkg::CMD_START, i2cm_pkg::CMD_ADDR));
        else m = MODE_UNUSED;
      end else begin
        if (r < 85) m = 3'($urandom_range(i2cm_pkg::CMD_START, i2cm_pkg::CMD_ADDR + 3));
        else if (r < 93) m = i2cm_pkg::CMD_TICK;
        else m = MODE_UNUSED;
        if (m > i2cm_pkg::CMD_ADDR && r < 85) begin
          m = (r % 3 == 0) ? i2cm_pkg::CMD_READ
                           : (r % 3 == 1) ? i2cm_pkg::CMD_WRITE : i2cm_pkg::CMD_ADDR;
        end
      end
      push(rand_request(m));
    end
  endtask

  initial begin
    int k;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 8'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 32'd0;
    s_axis_tuser = i2cm_pkg::CMD_TICK;
    tx_burst = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tick();
    push(rand_request(MODE_UNUSED));
    push(rand_request(i2cm_pkg::CMD_START));
    push(rand_request(i2cm_pkg::CMD_WRITE));
    repeat (3) tick();
    push(rand_request(i2cm_pkg::CMD_RESTART));
    repeat (6) tick();
    push(rand_request(i2cm_pkg::CMD_STOP));
    repeat (8) tick();

    random_traffic(370);
    set_rate(8'd2);
    random_traffic(200);
    set_rate(8'd255);
    push(rand_request(i2cm_pkg::CMD_START));
    for (k = 0; k < 780; k++) tick();
    set_rate(8'd3);
    random_traffic(150);
    set_rate(8'd1);
    random_traffic(60);

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int gap;
    int taken;
    logic rx_burst;
    m_axis_tready = 1'b0;
    taken = 0;
    rx_burst = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (taken % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (taken == 600 || taken == 1200) gap = LONG_HOLD;
      else gap = rx_burst ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt == IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
